>>> hw/rtl/tmvp_pkg.sv
// shared types, constants and helpers of the text mode video processor
`timescale 1ns / 1ps

package tmvp_pkg;

  localparam int unsigned AddrW       = 14;
  localparam int unsigned VramBytesDef = 16384;
  localparam int unsigned QDepth      = 2;
  localparam int unsigned NumRegs     = 8;
  localparam int unsigned CellOffW    = 11;
  localparam int unsigned RegNameBase = 2;
  localparam int unsigned RegPatBase  = 4;
  localparam int unsigned RegColour   = 7;
  localparam logic [15:0] DivSixMul   = 16'd171;

  typedef enum logic [2:0] {
    OP_SET_PTR    = 3'd0,
    OP_WRITE_BYTE = 3'd1,
    OP_READ_BYTE  = 3'd2,
    OP_WRITE_REG  = 3'd3,
    OP_READ_REG   = 3'd4,
    OP_PEEK       = 3'd5,
    OP_RENDER     = 3'd6,
    OP_NONE       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_NAME,
    BS_PAT,
    BS_MEM
  } bst_e;

  typedef struct packed {
    op_e                 op;
    logic [AddrW-1:0]    bus;
    logic [2:0]          reg_idx;
    logic [CellOffW-1:0] cell_off;
    logic [2:0]          x_mod;
    logic [2:0]          y_mod;
  } cmd_t;

  // mirror a 14-bit address into a memory of at least a quarter of the space
  function automatic logic [AddrW-1:0] fold_addr(input logic [AddrW-1:0] a,
                                                 input logic [AddrW+1:0] bytes);
    logic [AddrW+1:0] v;
    v = {2'b00, a};
    if (v >= (bytes << 1)) v = v - (bytes << 1);
    if (v >= bytes) v = v - bytes;
    return v[AddrW-1:0];
  endfunction

endpackage

>>> hw/rtl/tmvp_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module tmvp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tmvp_queue.sv
// short request queue between the decode front and the execute back
`timescale 1ns / 1ps

module tmvp_queue
  import tmvp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            entry_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

>>> hw/rtl/tmvp_front.sv
// request intake: operation decode and screen cell arithmetic
`timescale 1ns / 1ps

module tmvp_front
  import tmvp_pkg::*;
(
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       operation_i,
  input  logic [AddrW-1:0] bus_value_i,
  input  logic [2:0]       reg_index_i,
  input  logic [7:0]       pixel_x_i,
  input  logic [7:0]       pixel_y_i,
  input  logic             full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic [15:0]         prod;
  logic [5:0]          col;
  logic [7:0]          col_x6;
  logic [7:0]          x_rem;
  logic [4:0]          row;
  logic [CellOffW-1:0] row_x40;

  // column is x / 6 by reciprocal, exact for any 8-bit x
  always_comb begin
    prod    = 16'(pixel_x_i) * DivSixMul;
    col     = prod[15:10];
    col_x6  = {col, 2'b00} + {1'b0, col, 1'b0};
    x_rem   = pixel_x_i - col_x6;
    row     = pixel_y_i[7:3];
    row_x40 = {1'b0, row, 5'b0} + {3'b0, row, 3'b0};
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.op       = op_e'(operation_i);
    cmd_o.bus      = bus_value_i;
    cmd_o.reg_idx  = reg_index_i;
    cmd_o.cell_off = row_x40 + CellOffW'(col);
    cmd_o.x_mod    = x_rem[2:0];
    cmd_o.y_mod    = pixel_y_i[2:0];
  end

endmodule

>>> hw/rtl/tmvp_back.sv
// execute side: video memory, control registers, pointer and result register
`timescale 1ns / 1ps

module tmvp_back
  import tmvp_pkg::*;
#(
  parameter int unsigned VRAM_BYTES = VramBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_value_o,
  output logic [3:0] pixel_color_o,
  output logic       pixel_lit_o
);

  localparam int unsigned RamAw = $clog2(VRAM_BYTES);

  bst_e             state_q, state_d;
  cmd_t             cmd_q;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [7:0]       regs_q [NumRegs];

  logic             reg_we;
  logic [2:0]       reg_widx;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] wr_full, rd_full, wr_fold, rd_fold;
  logic [7:0]       ram_rdata;

  logic             out_valid_q, out_valid_d, out_load;
  logic [7:0]       read_value_q, read_value_d;
  logic [3:0]       pixel_color_q, pixel_color_d;
  logic             pixel_lit_q, pixel_lit_d;

  logic             out_free;
  logic [3:0]       fg, bg;
  logic             lit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign bg       = regs_q[RegColour][3:0];
  assign fg       = (regs_q[RegColour][7:4] == 4'd0) ? bg : regs_q[RegColour][7:4];
  assign lit      = ram_rdata[3'd7 - cmd_q.x_mod];

  assign wr_full = ptr_q;
  assign wr_fold = fold_addr(wr_full, (AddrW + 2)'(VRAM_BYTES));
  assign rd_fold = fold_addr(rd_full, (AddrW + 2)'(VRAM_BYTES));

  tmvp_ram #(
    .WIDTH (8),
    .DEPTH (VRAM_BYTES)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_fold[RamAw-1:0]),
    .wdata_i (cmd_i.bus[7:0]),
    .re_i    (ram_re),
    .raddr_i (rd_fold[RamAw-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    pop_o         = 1'b0;
    reg_we        = 1'b0;
    reg_widx      = cmd_i.reg_idx;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    rd_full       = cmd_i.bus;
    out_load      = 1'b0;
    read_value_d  = 8'd0;
    pixel_color_d = 4'd0;
    pixel_lit_d   = 1'b0;

    unique case (state_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_READ_BYTE: begin
              pop_o   = 1'b1;
              ram_re  = 1'b1;
              rd_full = ptr_q;
              ptr_d   = ptr_q + 1'b1;
              state_d = BS_MEM;
            end
            OP_PEEK: begin
              pop_o   = 1'b1;
              ram_re  = 1'b1;
              rd_full = cmd_i.bus;
              state_d = BS_MEM;
            end
            OP_RENDER: begin
              pop_o   = 1'b1;
              ram_re  = 1'b1;
              rd_full = {regs_q[RegNameBase][3:0], 10'b0} + AddrW'(cmd_i.cell_off);
              state_d = BS_NAME;
            end
            OP_SET_PTR, OP_WRITE_BYTE, OP_WRITE_REG, OP_READ_REG, OP_NONE: begin
              if (out_free) begin
                pop_o    = 1'b1;
                out_load = 1'b1;
                unique case (cmd_i.op)
                  OP_SET_PTR:    ptr_d = cmd_i.bus;
                  OP_WRITE_BYTE: begin
                    ram_we = 1'b1;
                    ptr_d  = ptr_q + 1'b1;
                  end
                  OP_WRITE_REG:  reg_we = 1'b1;
                  OP_READ_REG:   read_value_d = regs_q[cmd_i.reg_idx];
                  default:       ;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      BS_NAME: begin
        ram_re  = 1'b1;
        rd_full = {regs_q[RegPatBase][2:0], 11'b0} + {3'b0, ram_rdata, 3'b0}
                + AddrW'(cmd_q.y_mod);
        state_d = BS_PAT;
      end
      BS_PAT: begin
        if (out_free) begin
          out_load      = 1'b1;
          pixel_lit_d   = lit;
          pixel_color_d = lit ? fg : bg;
          state_d       = BS_IDLE;
        end
      end
      BS_MEM: begin
        if (out_free) begin
          out_load     = 1'b1;
          read_value_d = ram_rdata;
          state_d      = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase

    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= 8'd0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (reg_we) regs_q[reg_widx] <= cmd_i.bus[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (out_load) begin
      read_value_q  <= read_value_d;
      pixel_color_q <= pixel_color_d;
      pixel_lit_q   <= pixel_lit_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign pixel_color_o = pixel_color_q;
  assign pixel_lit_o   = pixel_lit_q;

endmodule

>>> hw/rtl/text_mode_video_processor.sv
// top level of the text mode video processor
//
//   channel  direction  handshake               payload
//   in       request    in_valid_i / in_stall_o  operation, bus value, reg index, x, y
//   out      result     out_valid_o / out_stall_i read value, pixel colour, pixel lit
//
// render does a name fetch then a pattern fetch on the one ram read port
// memory read and peek pass through a memory fetch state, all other requests finish from idle
// up to two requests wait in the queue while the back end is busy or stalled
// reset clears control registers, pointer and handshake state; vram is not cleared
// a stalled result holds in the output register while the queue keeps filling
`timescale 1ns / 1ps

module text_mode_video_processor
  import tmvp_pkg::*;
#(
  parameter int unsigned VRAM_BYTES = VramBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       operation_i,
  input  logic [AddrW-1:0] bus_value_i,
  input  logic [2:0]       reg_index_i,
  input  logic [7:0]       pixel_x_i,
  input  logic [7:0]       pixel_y_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       read_value_o,
  output logic [3:0]       pixel_color_o,
  output logic             pixel_lit_o
);

  logic q_full, q_push, q_valid, q_pop;
  cmd_t push_cmd, head_cmd;

  tmvp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .bus_value_i (bus_value_i),
    .reg_index_i (reg_index_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .cmd_o       (push_cmd)
  );

  tmvp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_cmd),
    .pop_i      (q_pop)
  );

  tmvp_back #(
    .VRAM_BYTES (VRAM_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .pixel_color_o (pixel_color_o),
    .pixel_lit_o   (pixel_lit_o)
  );

endmodule

>>> hw/rtl/tmvp_checker.sv
// port level checks of the text mode video processor and their binding
`timescale 1ns / 1ps

module tmvp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_value_o,
  input logic [3:0] pixel_color_o,
  input logic       pixel_lit_o
);

  logic       in_acc, out_acc;
  logic [2:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign pend_d  = pend_q + {2'b0, in_acc} - {2'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_value_o)
      && $stable(pixel_color_o) && $stable(pixel_lit_o))
    else $error("stalled result changed");

  // no result without an outstanding request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result without request");

  // queue, back end and output register bound the requests in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("too many requests in flight");

  // intake stalls only with the queue full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pend_q >= 3'd2)
    else $error("stall with room in queue");

  // a result with a nonzero read value never carries a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_value_o != 8'd0 |-> pixel_color_o == 4'd0 && !pixel_lit_o)
    else $error("read result carries pixel");

endmodule

bind text_mode_video_processor tmvp_checker u_checker (.*);
